/* rtl/tllh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllh_pkg
// Shared types and constants of the tagged latency log2 histogram.
// ----------------------------------------------------------------------------
package tllh_pkg;

  localparam int unsigned TRACK_ENTRIES_DEF = 1024;
  localparam int unsigned HIST_BINS_DEF     = 27;

  localparam logic [63:0] US_DIV = 64'd1000;
  localparam logic [63:0] MS_DIV = 64'd1000000;

  localparam logic CFG_FILTER = 1'b0;
  localparam logic CFG_UNIT   = 1'b1;

  typedef enum logic [1:0] {
    K_START,
    K_FINISH,
    K_READ,
    K_DROP
  } kind_e;

  typedef enum logic [2:0] {
    ST_STORED,
    ST_FULL,
    ST_FILT,
    ST_NOSTART,
    ST_NEG,
    ST_COUNT,
    ST_READ
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] tag;
    logic [63:0] time_ns;
    logic [4:0]  idx;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  bin;
    logic [31:0] count;
  } res_t;

endpackage
`default_nettype wire

/* rtl/tllh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllh_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tllh_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/tllh_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllh_front
// Accept events, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module tllh_front #(
  parameter int unsigned HIST_BINS = tllh_pkg::HIST_BINS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [1:0]    op_i,
  input  wire logic [63:0]   tag_i,
  input  wire logic [63:0]   time_ns_i,
  input  wire logic          in_group_i,
  input  wire logic [4:0]    bin_index_i,
  input  wire logic          filter_i,
  input  wire logic          clearing_i,
  output tllh_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i
);
  import tllh_pkg::*;

  cmd_t       cls;
  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  always_comb begin
    cls.tag     = tag_i;
    cls.time_ns = time_ns_i;
    cls.idx     = bin_index_i;
    if ({2'b00, bin_index_i} >= 7'(HIST_BINS)) begin
      cls.idx = 5'(HIST_BINS - 1);
    end
    if (op_i == K_READ) begin
      cls.kind = K_READ;
    end else if (op_i == K_DROP || (filter_i && !in_group_i)) begin
      cls.kind = K_DROP;
    end else if (op_i == K_START) begin
      cls.kind = K_START;
    end else begin
      cls.kind = K_FINISH;
    end
  end

  assign full_o      = (cnt_q == 2'd2) || clearing_i;
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

/* rtl/tllh_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllh_back
// Execute events: tag table scan, entry update, log2 binning, bin read or update.
// ----------------------------------------------------------------------------
module tllh_back #(
  parameter int unsigned TRACK_ENTRIES = tllh_pkg::TRACK_ENTRIES_DEF,
  parameter int unsigned HIST_BINS     = tllh_pkg::HIST_BINS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  tllh_pkg::cmd_t  cmd_i,
  input  wire logic       cmd_valid_i,
  output logic            cmd_pop_o,
  input  wire logic       unit_ms_i,
  output tllh_pkg::res_t  res_o,
  output logic            res_valid_o,
  input  wire logic       res_pop_i,
  output logic            clearing_o
);
  import tllh_pkg::*;

  localparam int unsigned AW      = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam int unsigned HBW     = $clog2(HIST_BINS);
  localparam int unsigned CLR_LEN = (TRACK_ENTRIES > HIST_BINS) ? TRACK_ENTRIES : HIST_BINS;
  localparam int unsigned CW      = $clog2(CLR_LEN + 1);
  localparam int unsigned TW      = 129;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_LOG,
    S_HRD
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  cmd_t            cmd_q;
  logic [AW-1:0]   chk_q, hit_idx_q, free_idx_q;
  logic            hit_q, free_q;
  logic [63:0]     hit_time_q;
  logic [62:0]     dist_q;
  logic [HBW-1:0]  bin_q;
  logic [64:0]     thr_q;
  res_t            res_q;
  logic            res_vld_q;

  logic            t_we;
  logic [AW-1:0]   t_waddr, t_raddr;
  logic [TW-1:0]   t_wdata, t_rdata;
  logic            h_we;
  logic [HBW-1:0]  h_waddr, h_raddr;
  logic [31:0]     h_wdata, h_rdata;

  logic            r_valid, match, last, log_done, res_set;
  logic [63:0]     diff;

  assign r_valid  = t_rdata[128];
  assign match    = r_valid && (t_rdata[127:64] == cmd_q.tag);
  assign last     = (chk_q == AW'(TRACK_ENTRIES - 1));
  assign diff     = cmd_q.time_ns - hit_time_q;
  assign log_done = (bin_q == HBW'(HIST_BINS - 1)) || ({2'b00, dist_q} < thr_q);

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i && !res_vld_q;
  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;
  assign clearing_o  = (state_q == S_CLEAR);

  // A result is produced by a dropped event, by any start, by a finish that
  // ends without counting, and by the histogram step.
  assign res_set = ((state_q == S_IDLE) && cmd_pop_o && (cmd_i.kind == K_DROP)) ||
                   ((state_q == S_ACT) &&
                    ((cmd_q.kind == K_START) || !hit_q || diff[63])) ||
                   (state_q == S_HRD);

  always_comb begin
    t_we    = 1'b0;
    t_waddr = chk_q;
    t_wdata = '0;
    t_raddr = '0;
    h_we    = 1'b0;
    h_waddr = bin_q;
    h_wdata = '0;
    h_raddr = bin_q;
    unique case (state_q)
      S_CLEAR: begin
        t_we    = (cnt_q < CW'(TRACK_ENTRIES));
        t_waddr = cnt_q[AW-1:0];
        h_we    = (cnt_q < CW'(HIST_BINS));
        h_waddr = cnt_q[HBW-1:0];
      end
      S_IDLE: begin
        h_raddr = HBW'(cmd_i.idx);
      end
      S_SCAN: begin
        t_raddr = chk_q + 1'b1;
      end
      S_ACT: begin
        if (cmd_q.kind == K_START) begin
          t_we    = hit_q || free_q;
          t_waddr = hit_q ? hit_idx_q : free_idx_q;
          t_wdata = {1'b1, cmd_q.tag, cmd_q.time_ns};
        end else begin
          t_we    = hit_q;
          t_waddr = hit_idx_q;
          t_wdata = {1'b0, cmd_q.tag, cmd_q.time_ns};
        end
      end
      S_LOG: begin
      end
      S_HRD: begin
        h_we    = (cmd_q.kind != K_READ);
        h_wdata = h_rdata + 32'd1;
      end
      default: begin
      end
    endcase
  end

  tllh_ram #(.W(TW), .D(TRACK_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  tllh_ram #(.W(32), .D(HIST_BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cnt_q      <= '0;
      res_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      chk_q      <= '0;
      bin_q      <= '0;
    end else begin
      if (res_set) begin
        res_vld_q <= 1'b1;
      end else if (res_pop_i) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (cnt_q == CW'(CLR_LEN - 1)) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_pop_o) begin
            cmd_q <= cmd_i;
            unique case (cmd_i.kind)
              K_DROP: begin
                res_q <= '{status: ST_FILT, bin: 5'd0, count: 32'd0};
              end
              K_READ: begin
                bin_q   <= HBW'(cmd_i.idx);
                state_q <= S_HRD;
              end
              default: begin
                hit_q   <= 1'b0;
                free_q  <= 1'b0;
                chk_q   <= '0;
                state_q <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= chk_q;
            hit_time_q <= t_rdata[63:0];
          end
          if (!r_valid && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= chk_q;
          end
          if (match || last) begin
            state_q <= S_ACT;
          end else begin
            chk_q <= chk_q + 1'b1;
          end
        end
        S_ACT: begin
          if (cmd_q.kind == K_START) begin
            res_q   <= '{status: (hit_q || free_q) ? ST_STORED : ST_FULL,
                         bin: 5'd0, count: 32'd0};
            state_q <= S_IDLE;
          end else if (!hit_q) begin
            res_q   <= '{status: ST_NOSTART, bin: 5'd0, count: 32'd0};
            state_q <= S_IDLE;
          end else if (diff[63]) begin
            res_q   <= '{status: ST_NEG, bin: 5'd0, count: 32'd0};
            state_q <= S_IDLE;
          end else begin
            dist_q  <= diff[62:0];
            bin_q   <= '0;
            thr_q   <= unit_ms_i ? {MS_DIV, 1'b0} : {US_DIV, 1'b0};
            state_q <= S_LOG;
          end
        end
        S_LOG: begin
          if (log_done) begin
            state_q <= S_HRD;
          end else begin
            bin_q <= bin_q + 1'b1;
            thr_q <= {thr_q[63:0], 1'b0};
          end
        end
        S_HRD: begin
          if (cmd_q.kind == K_READ) begin
            res_q <= '{status: ST_READ, bin: 5'(bin_q), count: h_rdata};
          end else begin
            res_q <= '{status: ST_COUNT, bin: 5'(bin_q), count: h_wdata};
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/tagged_latency_log2_histogram_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_latency_log2_histogram_top
// Request latency histogram with log2 bins keyed by request tag.
// ----------------------------------------------------------------------------
// Steps: a dropped event gets its result when it is taken; a read goes through
//   a histogram read; a start or finish event scans the tag table one entry a
//   cycle through its RAM read port, then for a counted finish log2 binning
//   and a histogram read-modify-write.
// Throughput: one event at a time in the back end; two more wait in the queue.
// Reset: after reset a clearing pass zeroes the tag table and histogram;
//   full_o stays high until it ends.
module tagged_latency_log2_histogram_top #(
  parameter int unsigned TRACK_ENTRIES = tllh_pkg::TRACK_ENTRIES_DEF,
  parameter int unsigned HIST_BINS     = tllh_pkg::HIST_BINS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // event queue side
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [63:0] tag_i,
  input  wire logic [63:0] time_ns_i,
  input  wire logic        in_group_i,
  input  wire logic [4:0]  bin_index_i,
  // result queue side
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [2:0]       status_o,
  output logic [4:0]       bin_o,
  output logic [31:0]      count_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic        cfg_data_i
);
  import tllh_pkg::*;

  logic filter_q, unit_ms_q;
  cmd_t cmd;
  logic cmd_valid, cmd_pop, clearing;
  res_t res;
  logic res_valid;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q  <= 1'b0;
      unit_ms_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER: filter_q  <= cfg_data_i;
        CFG_UNIT:   unit_ms_q <= cfg_data_i;
        default:    filter_q  <= filter_q;
      endcase
    end
  end

  // Front: classify each event (filter, unused op, bin saturation) and queue it.
  tllh_front #(.HIST_BINS(HIST_BINS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .op_i        (op_i),
    .tag_i       (tag_i),
    .time_ns_i   (time_ns_i),
    .in_group_i  (in_group_i),
    .bin_index_i (bin_index_i),
    .filter_i    (filter_q),
    .clearing_i  (clearing),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: table scan, entry update, binning and histogram update.
  tllh_back #(
    .TRACK_ENTRIES (TRACK_ENTRIES),
    .HIST_BINS     (HIST_BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .unit_ms_i   (unit_ms_q),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop_i),
    .clearing_o  (clearing)
  );

  // Hold the result in the back end's output register until its transfer.
  assign empty_o  = !res_valid;
  assign status_o = res.status;
  assign bin_o    = res.bin;
  assign count_o  = res.count;

  // No event is taken while the clearing pass runs.
  a_no_push_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full_o)
    else $error("event accepted during clearing pass");

  // Non-counting statuses carry zero bin and count.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (status_o == ST_STORED || status_o == ST_FULL ||
      status_o == ST_FILT || status_o == ST_NOSTART || status_o == ST_NEG))
    |-> (bin_o == 5'd0 && count_o == 32'd0))
    else $error("nonzero payload on non-counting status");

  // A waiting result holds until its transfer.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(status_o) && $stable(count_o)))
    else $error("result changed before transfer");

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the tagged latency histogram: drives start, finish, read and drop
// events through the event queue and checks each result against its own model.
// ----------------------------------------------------------------------------
module tb;
  import tllh_pkg::*;

  localparam int unsigned NENT  = TRACK_ENTRIES_DEF;
  localparam int unsigned NBINS = HIST_BINS_DEF;
  localparam int          IDLE_LIMIT = 20000;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] tag;
    logic [63:0] tns;
    logic        grp;
    logic [4:0]  idx;
  } event_t;

  typedef struct {
    logic [2:0]  status;
    logic [4:0]  bin;
    logic [31:0] count;
  } outcome_t;

  logic clk, rst_n;
  logic push, full;
  logic [1:0] op;
  logic [63:0] tag, tns;
  logic grp;
  logic [4:0] bidx;
  logic empty, pop;
  logic [2:0] status;
  logic [4:0] bin;
  logic [31:0] count;
  logic cfg_we, cfg_idx, cfg_data;
  logic full_q, empty_q;

  tagged_latency_log2_histogram_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .push_i(push), .full_o(full), .op_i(op), .tag_i(tag), .time_ns_i(tns),
    .in_group_i(grp), .bin_index_i(bidx),
    .empty_o(empty), .pop_i(pop), .status_o(status), .bin_o(bin), .count_o(count),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Predictor state
  logic        m_filter, m_unit_ms;
  logic        m_valid [NENT];
  logic [63:0] m_tag   [NENT];
  logic [63:0] m_start [NENT];
  logic [31:0] m_bins  [NBINS];

  event_t   pending_events[$];
  outcome_t expected_results[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       hold_results = 0;
  int       hold_cycles = 0;
  logic [63:0] tag_pool[$];
  logic [63:0] base_pool[$];

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic int lookup_tag(logic [63:0] t);
    for (int i = 0; i < NENT; i++) if (m_valid[i] && m_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic outcome_t predict_latency(event_t ev);
    outcome_t r;
    int e;
    logic [63:0] diff, q;
    int b;
    r.status = ST_FILT; r.bin = '0; r.count = '0;
    if (ev.op == K_READ) begin
      b = (ev.idx >= NBINS) ? NBINS - 1 : ev.idx;
      r.status = ST_READ; r.bin = 5'(b); r.count = m_bins[b];
      return r;
    end
    if (ev.op == K_DROP) return r;
    if (m_filter && !ev.grp) return r;
    e = lookup_tag(ev.tag);
    if (ev.op == K_START) begin
      if (e < 0)
        for (int i = 0; i < NENT; i++) if (!m_valid[i]) begin e = i; break; end
      if (e < 0) begin
        r.status = ST_FULL;
        return r;
      end
      m_valid[e] = 1'b1; m_tag[e] = ev.tag; m_start[e] = ev.tns;
      r.status = ST_STORED;
      return r;
    end
    if (e < 0) begin
      r.status = ST_NOSTART;
      return r;
    end
    m_valid[e] = 1'b0;
    diff = ev.tns - m_start[e];
    if (diff[63]) begin
      r.status = ST_NEG;
      return r;
    end
    q = diff / (m_unit_ms ? MS_DIV : US_DIV);
    b = 0;
    while (q > 1) begin q = q >> 1; b++; end
    if (b >= NBINS) b = NBINS - 1;
    m_bins[b] = m_bins[b] + 1;
    r.status = ST_COUNT; r.bin = 5'(b); r.count = m_bins[b];
    return r;
  endfunction

  // Driver: offer queued events after a random gap, advance on each transfer
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !full_q) begin
      // transfer took place at the last rising edge
      send_gap = $urandom_range(0, 6);
      if (send_gap == 0 && pending_events.size() > 0) drive_next();
      else push <= 1'b0;
    end else if (!push) begin
      if (send_gap > 0) send_gap--;
      else if (pending_events.size() > 0) drive_next();
    end
  end

  always @(posedge clk) begin
    full_q <= full;
    empty_q <= empty;
  end

  task automatic drive_next();
    event_t ev;
    ev = pending_events.pop_front();
    op <= ev.op; tag <= ev.tag; tns <= ev.tns; grp <= ev.grp; bidx <= ev.idx;
    push <= 1'b1;
  endtask

  // Accept side: predict on each input transfer, check on each result transfer
  always @(posedge clk) begin
    event_t ev;
    outcome_t exp_r;
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (push && !full) begin
        ev.op = op; ev.tag = tag; ev.tns = tns; ev.grp = grp; ev.idx = bidx;
        expected_results.push_back(predict_latency(ev));
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d bin=%0d count=%0d",
                   $realtime, status, bin, count);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, status);
            errors++;
          end
          if (bin !== exp_r.bin) begin
            $display("%0t: bin expected %0d actual %0d", $realtime, exp_r.bin, bin);
            errors++;
          end
          if (count !== exp_r.count) begin
            $display("%0t: count expected %0d actual %0d", $realtime, exp_r.count, count);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Monitor side pop control: random stalls, plus a long hold when asked
  int pop_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_results) begin
      pop <= 1'b0;
      hold_cycles++;
    end else if (pop && !empty_q) begin
      pop_gap = $urandom_range(0, 6);
      if (pop_gap != 0) pop <= 1'b0;
    end else if (!pop) begin
      if (pop_gap > 0) pop_gap--;
      else pop <= 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_event(logic [1:0] o, logic [63:0] t, logic [63:0] ts,
                           logic g, logic [4:0] i);
    event_t ev;
    ev.op = o; ev.tag = t; ev.tns = ts; ev.grp = g; ev.idx = i;
    pending_events.push_back(ev);
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || push) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (NENT + NBINS + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic i, logic d);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= i; cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (i == CFG_FILTER) m_filter = d; else m_unit_ms = d;
  endtask

  // Random phase: mostly matched start/finish pairs, with noise
  task automatic random_phase(int n);
    logic [63:0] t, base, lat, b0;
    int sel, k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40 || tag_pool.size() == 0) begin
        t = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 40));
        base = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom);
        tag_pool.push_back(t);
        base_pool.push_back(base);
        add_event(K_START, t, base, $urandom_range(0, 7) != 0, 5'($urandom));
      end else if (sel < 80) begin
        k = $urandom_range(0, tag_pool.size() - 1);
        t = tag_pool[k];
        b0 = base_pool[k];
        tag_pool.delete(k);
        base_pool.delete(k);
        lat = 64'(1) << $urandom_range(0, 63);
        lat = lat + ($urandom & (lat - 1));
        add_event(K_FINISH, t, ($urandom_range(0, 7) == 0) ? b0 - lat : b0 + lat,
                  $urandom_range(0, 7) != 0, 5'($urandom));
      end else if (sel < 93) begin
        add_event(K_READ, rand64(), rand64(), 1'($urandom), 5'($urandom));
      end else begin
        add_event(2'($urandom_range(0, 3)), rand64(), rand64(), 1'($urandom),
                  5'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0; pop = 1'b0;
    op = '0; tag = '0; tns = '0; grp = 1'b0; bidx = '0;
    cfg_we = 1'b0; cfg_idx = 1'b0; cfg_data = 1'b0;
    m_filter = 1'b0; m_unit_ms = 1'b0;
    for (int i = 0; i < NENT; i++) begin m_valid[i] = 0; m_tag[i] = 0; m_start[i] = 0; end
    for (int i = 0; i < NBINS; i++) m_bins[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    write_reg(CFG_FILTER, 1'b0);
    write_reg(CFG_UNIT, 1'b0);

    // Directed: field extremes, every op, the special cases
    add_event(K_READ, 64'd0, 64'd0, 1'b0, 5'd0);
    add_event(K_READ, '1, '1, 1'b1, 5'd31);            // index saturates
    add_event(K_FINISH, 64'd5, 64'd100, 1'b1, 5'd0);   // finish with no start
    add_event(K_START, 64'd5, 64'd0, 1'b1, 5'd0);
    add_event(K_START, 64'd5, 64'd1000, 1'b0, 5'd0);   // replace timestamp
    add_event(K_FINISH, 64'd5, 64'd2999, 1'b1, 5'd0);  // 1 us -> bin 0
    add_event(K_START, '1, 64'd0, 1'b1, 5'd0);
    add_event(K_FINISH, '1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd0); // clamp top bin
    add_event(K_START, 64'd7, 64'd500, 1'b1, 5'd0);
    add_event(K_FINISH, 64'd7, 64'd499, 1'b1, 5'd0);   // negative difference
    add_event(K_START, 64'd8, '1, 1'b1, 5'd0);
    add_event(K_FINISH, 64'd8, 64'd10_000, 1'b1, 5'd0); // wraps non-negative
    add_event(K_DROP, '1, '1, 1'b1, 5'd31);            // unused op
    add_event(K_READ, 64'd0, 64'd0, 1'b0, 5'd26);
    drain();

    write_reg(CFG_FILTER, 1'b1);
    add_event(K_START, 64'd9, 64'd0, 1'b0, 5'd0);      // filtered start
    add_event(K_START, 64'd9, 64'd0, 1'b1, 5'd0);
    add_event(K_FINISH, 64'd9, 64'd5000, 1'b0, 5'd0);  // filtered finish keeps entry
    add_event(K_FINISH, 64'd9, 64'd5000, 1'b1, 5'd0);
    add_event(K_READ, 64'd0, 64'd0, 1'b0, 5'd2);       // reads never filtered
    drain();

    write_reg(CFG_UNIT, 1'b1);
    random_phase(250);
    // Hold the result side long enough to fill the block and stall its input
    hold_results = 1'b1;
    drain_inputs_only: while (hold_cycles < 3000) @(posedge clk);
    hold_results = 1'b0;
    drain();

    write_reg(CFG_FILTER, 1'b0);
    random_phase(200);
    drain();   // sender pauses until every result is back

    write_reg(CFG_UNIT, 1'b0);
    random_phase(200);
    drain();

    // Fill the tag table to reach the table-full case
    write_reg(CFG_UNIT, 1'b1);
    for (int i = 0; i < NENT + 4; i++)
      add_event(K_START, 64'h1_0000 + i, 64'(i), 1'b1, 5'd0);
    random_phase(100);
    drain();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
